>>> rtl/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion converter.
// No dependencies.
package rmq_pkg;

   localparam int COMP_W = 16;   // width of one matrix element or quaternion part
   localparam int TR_W   = 18;   // width of a sum of three elements
   localparam int NUM_W  = 17;   // width of a sum or difference of two elements

   typedef struct packed {
      logic signed [COMP_W-1:0] r00;
      logic signed [COMP_W-1:0] r01;
      logic signed [COMP_W-1:0] r02;
      logic signed [COMP_W-1:0] r10;
      logic signed [COMP_W-1:0] r11;
      logic signed [COMP_W-1:0] r12;
      logic signed [COMP_W-1:0] r20;
      logic signed [COMP_W-1:0] r21;
      logic signed [COMP_W-1:0] r22;
   } req_type;

   typedef struct packed {
      logic signed [COMP_W-1:0] qw;
      logic signed [COMP_W-1:0] qx;
      logic signed [COMP_W-1:0] qy;
      logic signed [COMP_W-1:0] qz;
   } rsp_type;

   // Which quaternion part is taken from the square root
   typedef enum logic [1:0] {
      ROOT_QW,
      ROOT_QX,
      ROOT_QY,
      ROOT_QZ
   } root_sel_type;

endpackage

>>> rtl/rmq_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on rmq_pkg; carries an opaque side vector alongside each request.
module rmq_sqrt #(
   parameter int FRAC_BITS = 14,
   parameter int S_W       = 19,
   parameter int RT_W      = 16,
   parameter int SIDE_W    = 53
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [S_W-1:0]    in_s,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [RT_W-1:0]   out_root,
   output logic [SIDE_W-1:0] out_side
);
   import rmq_pkg::*;

   localparam int RAD_W = 2 * RT_W;

   logic              vld_ff  [RT_W];
   logic [RAD_W-1:0]  rem_ff  [RT_W];
   logic [RT_W-1:0]   root_ff [RT_W];
   logic [SIDE_W-1:0] side_ff [RT_W];

   logic [RAD_W-1:0]  rem_in  [RT_W];
   logic [RT_W-1:0]   root_in [RT_W];
   logic              rdy     [RT_W+1];

   // Stage k decides root bit RT_W-1-k
   always_comb begin
      logic [RAD_W-1:0] rem_src;
      logic [RT_W-1:0]  root_src;
      logic [RAD_W-1:0] trial;
      for (int k = 0; k < RT_W; k++) begin
         if (k == 0) begin
            rem_src  = RAD_W'(in_s) << (FRAC_BITS - 2);
            root_src = '0;
         end else begin
            rem_src  = rem_ff[k-1];
            root_src = root_ff[k-1];
         end
         trial = (RAD_W'(root_src) << (RT_W - k)) | (RAD_W'(1) << (2 * (RT_W - 1 - k)));
         if (rem_src >= trial) begin
            rem_in[k]  = rem_src - trial;
            root_in[k] = root_src | (RT_W'(1) << (RT_W - 1 - k));
         end else begin
            rem_in[k]  = rem_src;
            root_in[k] = root_src;
         end
      end
   end

   // Advance a stage when it is empty or its successor advances
   always_comb begin
      rdy[RT_W] = out_ready;
      for (int k = RT_W - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < RT_W; k++) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            vld_ff[k] <= (k == 0) ? in_valid : vld_ff[k-1];
         end
         if (rdy[k]) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            side_ff[k] <= (k == 0) ? in_side : side_ff[k-1];
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[RT_W-1];
   assign out_root  = root_ff[RT_W-1];
   assign out_side  = side_ff[RT_W-1];

`ifndef SYNTHESIS
   // Exact floor root leaves a remainder of at most twice the root
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[RT_W-1] |-> (rem_ff[RT_W-1] <= (RAD_W'(root_ff[RT_W-1]) << 1)))
      else $error("sqrt remainder out of range");
   // Holding off the source only happens with the first stage occupied
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> vld_ff[0])
      else $error("sqrt stalled while empty");
`endif

endmodule

>>> rtl/rmq_div.sv
// Pipelined restoring divider: three numerators over four times the root,
// saturation and placement into the quaternion. Depends on rmq_pkg.
module rmq_div #(
   parameter int FRAC_BITS = 14,
   parameter int RT_W      = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [RT_W-1:0]       in_root,
   input  rmq_pkg::root_sel_type in_sel,
   input  logic [3*rmq_pkg::NUM_W-1:0] in_nums,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rmq_pkg::rsp_type      rsp
);
   import rmq_pkg::*;

   localparam int QB    = NUM_W;
   localparam int DEN_W = RT_W + 2;
   localparam int DV_W  = NUM_W + FRAC_BITS;
   localparam int CW    = (DV_W > DEN_W + QB) ? DV_W : DEN_W + QB;

   // stage 0 prepares, stages 1..QB each resolve one quotient bit
   logic               vld_ff  [QB+1];
   logic [DEN_W-1:0]   den_ff  [QB+1];
   logic [RT_W-1:0]    root_ff [QB+1];
   root_sel_type       sel_ff  [QB+1];
   logic               zero_ff [QB+1];
   logic [CW-1:0]      rem_ff  [QB+1][3];
   logic [QB-1:0]      quo_ff  [QB+1][3];
   logic               neg_ff  [QB+1][3];
   logic               ovf_ff  [QB+1][3];

   logic [CW-1:0]      rem_in  [QB+1][3];
   logic [QB-1:0]      quo_in  [QB+1][3];
   logic               neg_in  [3];
   logic               ovf_in  [3];
   logic               rdy     [QB+2];

   logic               out_vld_ff;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;

   function automatic logic [COMP_W-1:0] sat_part(input logic [QB-1:0] q, input logic neg,
                                                  input logic ovf, input logic zero);
      logic [COMP_W-1:0] r;
      if (zero) begin
         r = '0;
      end else if (!neg) begin
         r = (ovf || q > QB'(32767)) ? COMP_W'(32767) : q[COMP_W-1:0];
      end else begin
         r = (ovf || q > QB'(32768)) ? COMP_W'(32768) : COMP_W'(-q);
      end
      return r;
   endfunction

   always_comb begin
      logic [DEN_W-1:0] den0;
      logic [NUM_W-1:0] num;
      logic [NUM_W-1:0] mag;
      logic [CW-1:0]    trial;
      den0 = {in_root, 2'b00};
      for (int j = 0; j < 3; j++) begin
         num       = in_nums[j*NUM_W +: NUM_W];
         neg_in[j] = num[NUM_W-1];
         mag       = neg_in[j] ? -num : num;
         rem_in[0][j] = CW'(mag) << FRAC_BITS;
         quo_in[0][j] = '0;
         ovf_in[j]    = rem_in[0][j] >= (CW'(den0) << QB);
      end
      for (int k = 1; k <= QB; k++) begin
         for (int j = 0; j < 3; j++) begin
            trial = CW'(den_ff[k-1]) << (QB - k);
            if (rem_ff[k-1][j] >= trial) begin
               rem_in[k][j] = rem_ff[k-1][j] - trial;
               quo_in[k][j] = quo_ff[k-1][j] | (QB'(1) << (QB - k));
            end else begin
               rem_in[k][j] = rem_ff[k-1][j];
               quo_in[k][j] = quo_ff[k-1][j];
            end
         end
      end
   end

   // Saturate and place the root part by branch
   always_comb begin
      logic [COMP_W-1:0] root_s;
      logic [COMP_W-1:0] c0;
      logic [COMP_W-1:0] c1;
      logic [COMP_W-1:0] c2;
      root_s = (32'(root_ff[QB]) > 32'd32767) ? COMP_W'(32767) : COMP_W'(root_ff[QB]);
      c0 = sat_part(quo_ff[QB][0], neg_ff[QB][0], ovf_ff[QB][0], zero_ff[QB]);
      c1 = sat_part(quo_ff[QB][1], neg_ff[QB][1], ovf_ff[QB][1], zero_ff[QB]);
      c2 = sat_part(quo_ff[QB][2], neg_ff[QB][2], ovf_ff[QB][2], zero_ff[QB]);
      unique case (sel_ff[QB])
         ROOT_QW: rsp_in = '{qw: root_s, qx: c0, qy: c1, qz: c2};
         ROOT_QX: rsp_in = '{qw: c0, qx: root_s, qy: c1, qz: c2};
         ROOT_QY: rsp_in = '{qw: c0, qx: c1, qy: root_s, qz: c2};
         ROOT_QZ: rsp_in = '{qw: c0, qx: c1, qy: c2, qz: root_s};
         default: rsp_in = '0;
      endcase
   end

   always_comb begin
      rdy[QB+1] = !out_vld_ff || rsp_ready;
      for (int k = QB; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= QB; k++) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            vld_ff[k] <= (k == 0) ? in_valid : vld_ff[k-1];
         end
         if (rdy[k]) begin
            den_ff[k]  <= (k == 0) ? {in_root, 2'b00} : den_ff[k-1];
            root_ff[k] <= (k == 0) ? in_root : root_ff[k-1];
            sel_ff[k]  <= (k == 0) ? in_sel : sel_ff[k-1];
            zero_ff[k] <= (k == 0) ? (in_root == '0) : zero_ff[k-1];
            for (int j = 0; j < 3; j++) begin
               rem_ff[k][j] <= rem_in[k][j];
               quo_ff[k][j] <= quo_in[k][j];
               neg_ff[k][j] <= (k == 0) ? neg_in[j] : neg_ff[k-1][j];
               ovf_ff[k][j] <= (k == 0) ? ovf_in[j] : ovf_ff[k-1][j];
            end
         end
      end
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (rdy[QB+1]) begin
         out_vld_ff <= vld_ff[QB];
      end
      if (rdy[QB+1]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign in_ready  = rdy[0];
   assign rsp_valid = out_vld_ff;
   assign rsp       = rsp_ff;

`ifndef SYNTHESIS
   // A finished in-range division leaves a remainder below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[QB] && !zero_ff[QB]) |->
         ((ovf_ff[QB][0] || rem_ff[QB][0] < CW'(den_ff[QB])) &&
          (ovf_ff[QB][1] || rem_ff[QB][1] < CW'(den_ff[QB])) &&
          (ovf_ff[QB][2] || rem_ff[QB][2] < CW'(den_ff[QB]))))
      else $error("divider remainder not below divisor");
   // The root part, when the branch places it in qw, never comes out negative
   a_root_sign: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[QB] && rdy[QB+1] && sel_ff[QB] == ROOT_QW) |=> !rsp_ff.qw[COMP_W-1])
      else $error("negative root part");
`endif

endmodule

>>> rtl/rotation_matrix_to_quaternion_top.sv
// Rotation matrix to unit quaternion converter, top level.
// Depends on rmq_pkg, rmq_sqrt and rmq_div.
//
// Usage: present the nine Q2.14 matrix elements on req with req_valid; a
// request is taken on a clock edge where req_valid and req_ready are both high.
// The quaternion (qw, qx, qy, qz), Q2.14 saturated, appears on rsp with
// rsp_valid and is taken when rsp_ready is high.
// Throughput: one request per cycle, no gaps, while rsp_ready is high. The
// path from acceptance to rsp_valid runs through one front stage for trace,
// branch and radicand, RT_W square root stages (one root bit each), a prep
// stage, 17 divide stages (one quotient bit each, three lanes) and the
// output register. The root bit chain and the quotient bit chain set the depth.
// Every stage has its own valid bit; a stage advances when it is empty or the
// stage after it advances, so bubbles close up under a stall and the block
// keeps taking requests until every stage is full.
// When rsp_ready is low, hold the result and back-pressure stage by stage.
// Reset (synchronous, active high) clears all valid bits; data needs none.
module rotation_matrix_to_quaternion_top #(
   parameter int FRAC_BITS = 14
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rmq_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rmq_pkg::rsp_type rsp
);
   import rmq_pkg::*;

   // s = one plus a signed diagonal sum, clamped at zero
   localparam int S_W    = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
   localparam int S_SW   = S_W + 1;
   localparam int RAD_W  = S_W + FRAC_BITS - 2;
   localparam int RT_W   = (RAD_W + 1) / 2;
   localparam int SIDE_W = $bits(root_sel_type) + 3 * NUM_W;
   localparam int TRACE_EPS = (1 << FRAC_BITS) / 100000000;
   localparam logic signed [S_SW-1:0] ONE_S = S_SW'(1) << FRAC_BITS;

   logic              vld0_ff;
   logic [S_W-1:0]    s0_ff;
   logic [SIDE_W-1:0] side0_ff;
   logic [S_W-1:0]    s0_in;
   logic [SIDE_W-1:0] side0_in;
   logic              ready0;

   logic              sq_ready;
   logic              sq_valid;
   logic [RT_W-1:0]   sq_root;
   logic [SIDE_W-1:0] sq_side;
   logic              dv_ready;

   // Front stage: trace, branch pick, radicand and the three numerators
   always_comb begin
      logic signed [TR_W-1:0]  trace;
      logic signed [TR_W-1:0]  dsum;
      logic signed [S_SW-1:0]  s_full;
      logic signed [NUM_W-1:0] n0;
      logic signed [NUM_W-1:0] n1;
      logic signed [NUM_W-1:0] n2;
      root_sel_type            sel;
      trace = TR_W'(req.r00) + TR_W'(req.r11) + TR_W'(req.r22);
      if (trace > TR_W'(TRACE_EPS)) begin
         sel  = ROOT_QW;
         dsum = trace;
         n0   = NUM_W'(req.r12) - NUM_W'(req.r21);
         n1   = NUM_W'(req.r20) - NUM_W'(req.r02);
         n2   = NUM_W'(req.r01) - NUM_W'(req.r10);
      end else if (req.r00 > req.r11 && req.r00 > req.r22) begin
         sel  = ROOT_QX;
         dsum = TR_W'(req.r00) - TR_W'(req.r11) - TR_W'(req.r22);
         n0   = NUM_W'(req.r12) - NUM_W'(req.r21);
         n1   = NUM_W'(req.r01) + NUM_W'(req.r10);
         n2   = NUM_W'(req.r02) + NUM_W'(req.r20);
      end else if (req.r11 > req.r22) begin
         sel  = ROOT_QY;
         dsum = TR_W'(req.r11) - TR_W'(req.r00) - TR_W'(req.r22);
         n0   = NUM_W'(req.r20) - NUM_W'(req.r02);
         n1   = NUM_W'(req.r01) + NUM_W'(req.r10);
         n2   = NUM_W'(req.r12) + NUM_W'(req.r21);
      end else begin
         sel  = ROOT_QZ;
         dsum = TR_W'(req.r22) - TR_W'(req.r00) - TR_W'(req.r11);
         n0   = NUM_W'(req.r01) - NUM_W'(req.r10);
         n1   = NUM_W'(req.r02) + NUM_W'(req.r20);
         n2   = NUM_W'(req.r12) + NUM_W'(req.r21);
      end
      s_full   = S_SW'(dsum) + ONE_S;
      // drop a negative radicand to zero
      s0_in    = (s_full <= 0) ? '0 : s_full[S_W-1:0];
      side0_in = {sel, n2, n1, n0};
   end

   assign ready0    = !vld0_ff || sq_ready;
   assign req_ready = ready0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
      end else if (ready0) begin
         vld0_ff <= req_valid;
      end
      if (ready0) begin
         s0_ff    <= s0_in;
         side0_ff <= side0_in;
      end
   end

   rmq_sqrt #(
      .FRAC_BITS (FRAC_BITS),
      .S_W       (S_W),
      .RT_W      (RT_W),
      .SIDE_W    (SIDE_W)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld0_ff),
      .in_ready  (sq_ready),
      .in_s      (s0_ff),
      .in_side   (side0_ff),
      .out_valid (sq_valid),
      .out_ready (dv_ready),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   rmq_div #(
      .FRAC_BITS (FRAC_BITS),
      .RT_W      (RT_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_ready  (dv_ready),
      .in_root   (sq_root),
      .in_sel    (root_sel_type'(sq_side[SIDE_W-1 -: $bits(root_sel_type)])),
      .in_nums   (sq_side[3*NUM_W-1:0]),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

`ifndef SYNTHESIS
   // The front stage only refuses a request while it holds one
   a_front_hold: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> vld0_ff)
      else $error("front stage stalled while empty");
   // A held front item moves on once the root pipeline takes it
   a_front_move: assert property (@(posedge clock) disable iff (reset)
      (vld0_ff && sq_ready && !req_valid) |=> !vld0_ff)
      else $error("front stage item not released");
`endif

endmodule
